@@ rtl/lpdms_pkg.sv @@
// Package for the long-press drive mode selector.
// Holds poll/result types, mode codes and the mode-advance function.
// No dependencies.
package lpdms_pkg;

  localparam int unsigned NowW    = 32;
  localparam int unsigned StatusW = 16;
  localparam int unsigned ThreshW = 16;
  localparam int unsigned ModeW   = 3;
  localparam int unsigned FixBit  = 2;
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 8;
  localparam int unsigned CfgDataW = 16;

  localparam logic [ThreshW-1:0] ThreshReset = 16'd1000;

  // drive mode codes; list index equals code
  localparam logic [ModeW-1:0] MODE_ALL_FOUR   = 3'd0;
  localparam logic [ModeW-1:0] MODE_FRONT      = 3'd1;
  localparam logic [ModeW-1:0] MODE_REAR       = 3'd2;
  localparam logic [ModeW-1:0] MODE_OPEN_NOPID = 3'd3;
  localparam logic [ModeW-1:0] MODE_OPEN_DIFF  = 3'd4;
  localparam logic [ModeW-1:0] MODE_VECTORING  = 3'd5;

  localparam logic [ModeW-1:0] ModesWithFix    = 3'd6;
  localparam logic [ModeW-1:0] ModesWithoutFix = 3'd3;

  typedef struct packed {
    logic [NowW-1:0]    now_ms;
    logic [StatusW-1:0] nav_status;
    logic               button_pressed;
  } poll_t;

  typedef struct packed {
    logic             mode_changed;
    logic [ModeW-1:0] drive_mode;
  } result_t;

  // (mode + 1) mod list length, for any 3-bit mode
  function automatic logic [ModeW-1:0] next_mode(input logic [ModeW-1:0] mode,
                                                 input logic fix);
    logic [ModeW-1:0] res;
    res = MODE_ALL_FOUR;
    if (fix) begin
      case (mode)
        MODE_ALL_FOUR:   res = MODE_FRONT;
        MODE_FRONT:      res = MODE_REAR;
        MODE_REAR:       res = MODE_OPEN_NOPID;
        MODE_OPEN_NOPID: res = MODE_OPEN_DIFF;
        MODE_OPEN_DIFF:  res = MODE_VECTORING;
        MODE_VECTORING:  res = MODE_ALL_FOUR;
        3'd6:            res = MODE_FRONT;   // 7 mod 6
        default:         res = MODE_REAR;    // 8 mod 6
      endcase
    end else begin
      case (mode)
        MODE_ALL_FOUR:   res = MODE_FRONT;
        MODE_FRONT:      res = MODE_REAR;
        MODE_REAR:       res = MODE_ALL_FOUR;
        MODE_OPEN_NOPID: res = MODE_FRONT;
        MODE_OPEN_DIFF:  res = MODE_REAR;
        MODE_VECTORING:  res = MODE_ALL_FOUR;
        3'd6:            res = MODE_FRONT;
        default:         res = MODE_REAR;
      endcase
    end
    return res;
  endfunction

endpackage

@@ rtl/lpdms_in_reg.sv @@
// Input register stage of the long-press drive mode selector.
// Unpacks the input word into a poll_t; uses lpdms_pkg.
module lpdms_in_reg
  import lpdms_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [InDataW-1:0] in_tdata,   // button_pressed, nav_status, now_ms; zero pad
  output logic               poll_valid,
  input  logic               poll_ready,
  output poll_t              poll
);

  logic  valid_r;
  poll_t poll_r;

  assign in_tready  = !valid_r || poll_ready;
  assign poll_valid = valid_r;
  assign poll       = poll_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      poll_r.button_pressed <= in_tdata[0];
      poll_r.nav_status     <= in_tdata[StatusW:1];
      poll_r.now_ms         <= in_tdata[StatusW+NowW:StatusW+1];
    end
  end

endmodule

@@ rtl/lpdms_core.sv @@
// Mode state, press tracking and result register of the drive mode selector.
// One registered poll in, one result word out; uses lpdms_pkg.
module lpdms_core
  import lpdms_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               poll_valid,
  output logic               poll_ready,
  input  poll_t              poll,
  input  logic [ThreshW-1:0] threshold,
  output logic               res_valid,
  input  logic               res_ready,
  output result_t            res
);

  logic [ModeW-1:0] mode_r, mode_nxt;
  logic             prev_button_r;
  logic [NowW-1:0]  press_time_r, press_time_nxt;
  logic             pending_r, pending_nxt;
  logic             prev_fix_r;
  logic             res_valid_r;
  result_t          res_r;

  logic             fix, fix_change, rise, advance, fire;
  logic [ModeW-1:0] mode_fb;
  logic [NowW-1:0]  held;

  assign poll_ready = !res_valid_r || res_ready;
  assign fire       = poll_valid && poll_ready;
  assign res_valid  = res_valid_r;
  assign res        = res_r;

  always_comb begin
    fix        = poll.nav_status[FixBit];
    fix_change = fix != prev_fix_r;
    mode_fb    = mode_r;
    if (fix_change && !fix && mode_r >= ModesWithoutFix) begin
      mode_fb = MODE_ALL_FOUR;
    end
    if (fix_change && fix && mode_r >= ModesWithFix) begin
      mode_fb = MODE_ALL_FOUR;
    end
    pending_nxt    = pending_r && !fix_change;
    press_time_nxt = press_time_r;
    rise           = poll.button_pressed && !prev_button_r;
    if (rise) begin
      pending_nxt    = 1'b1;
      press_time_nxt = poll.now_ms;
    end
    if (!poll.button_pressed) begin
      pending_nxt = 1'b0;
    end
    held     = poll.now_ms - press_time_nxt;   // wraps mod 2^32
    advance  = pending_nxt && poll.button_pressed && (held > {16'd0, threshold});
    mode_nxt = mode_fb;
    if (advance) begin
      mode_nxt    = next_mode(mode_fb, fix);
      pending_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_ALL_FOUR;
      prev_button_r <= 1'b0;
      press_time_r  <= '0;
      pending_r     <= 1'b0;
      prev_fix_r    <= 1'b0;
      res_valid_r   <= 1'b0;
    end else begin
      if (poll_ready) begin
        res_valid_r <= poll_valid;
      end
      if (fire) begin
        mode_r        <= mode_nxt;
        prev_button_r <= poll.button_pressed;
        press_time_r  <= press_time_nxt;
        pending_r     <= pending_nxt;
        prev_fix_r    <= fix;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r.drive_mode   <= mode_nxt;
      res_r.mode_changed <= mode_nxt != mode_r;
    end
  end

  // without a fix only the first three modes are reachable
  a_mode_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    !prev_fix_r |-> mode_r < ModesWithoutFix)
    else $error("mode outside no-fix list");

  a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r < ModesWithFix)
    else $error("mode code out of range");

  a_release_cancels: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !poll.button_pressed |=> !pending_r)
    else $error("press still pending after release");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && !res_ready |=> res_valid_r && $stable(res_r))
    else $error("stalled result lost or changed");

  a_changed_flag: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> res_r.mode_changed == (mode_r != $past(mode_r)))
    else $error("changed flag disagrees with mode state");

endmodule

@@ rtl/long_press_drive_mode_selector.sv @@
// Long-press drive mode selector (top level).
// Input stream in, one result word per poll out, threshold write port.
// Instantiates lpdms_in_reg and lpdms_core; uses lpdms_pkg.
//
// Usage:
//   in_*  : one word per poll: button level, navigation status (bit 2 =
//           position fix) and the millisecond tick.
//   out_* : one word per poll: current drive mode and a flag set when that
//           poll changed the mode.
//   cfg_* : writes the 16-bit hold threshold in ms; always ready. Write only
//           while no poll is in flight.
// An accepted poll passes the input register, then the result register, on
// to output valid. One poll per cycle while out_tready is high: each register
// hands off in the same cycle it is refilled, so state updates once per poll.
// A stalled out_tready holds the result word; one more poll sits in the input
// register, after which in_tready drops.
// Reset (rst_n low, synchronous) sets mode 0, no pending press, no fix, the
// threshold to 1000 ms, and empties both registers.
module long_press_drive_mode_selector
  import lpdms_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,   // [0] button_pressed, [16:1] nav_status, [48:17] now_ms
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata,  // [2:0] drive_mode, [3] mode_changed
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgDataW-1:0] cfg_data    // hold_threshold_ms
);

  logic               poll_valid, poll_ready;
  poll_t              poll;
  result_t            res;
  logic [ThreshW-1:0] threshold_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= ThreshReset;
    end else if (cfg_valid) begin
      threshold_r <= cfg_data;
    end
  end

  lpdms_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .poll_valid (poll_valid),
    .poll_ready (poll_ready),
    .poll       (poll)
  );

  lpdms_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .poll_valid (poll_valid),
    .poll_ready (poll_ready),
    .poll       (poll),
    .threshold  (threshold_r),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res        (res)
  );

  assign out_tdata = {{(OutDataW - ModeW - 1){1'b0}}, res};

endmodule
